@@ rtl/btgr_pkg.sv @@
// Shared constants, font tables and a helper function of the bitmap text glyph renderer.
package btgr_pkg;

  localparam int unsigned CodeW      = 8;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned CursorW    = 12;
  localparam int unsigned StrideW    = 10;
  localparam int unsigned BaseW      = 24;
  localparam int unsigned AddrW      = 25;
  localparam int unsigned RowW       = 3;
  localparam int unsigned PixelW     = 16;
  localparam int unsigned GlyphW     = 6;
  localparam int unsigned WordIdxW   = 6;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 24;

  localparam logic [RowW-1:0]     LastRow      = 3'd6;
  localparam logic [CursorW-1:0]  GlyphAdvance = 12'd6;
  localparam logic [7:0]          NoGlyph      = 8'hFF;
  localparam logic [PixelW-1:0]   PixelSet     = 16'hFFFF;
  localparam logic [PixelW-1:0]   PixelClear   = 16'h0001;
  localparam logic [StrideW-1:0]  FbWidthReset = 10'd320;
  localparam logic [BaseW-1:0]    FrameBaseReset = 24'd0;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0]  RegFbWidth   = 4'd0;
  localparam logic [CfgIdxW-1:0]  RegFrameBase = 4'd1;

  // Character code to glyph index; NoGlyph marks an unprintable character.
  localparam logic [7:0] GLYPH_MAP [128] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'h29, 8'hFF, 8'hFF, 8'hFF, 8'h2B, 8'hFF, 8'hFF,
    8'h25, 8'h26, 8'hFF, 8'h2A, 8'hFF, 8'h27, 8'h2C, 8'hFF,
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h24, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h28,
    8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20,
    8'h21, 8'h22, 8'h23, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20,
    8'h21, 8'h22, 8'h23, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  // Five 6x7 glyphs per group of seven words, leftmost glyph in the top bits.
  localparam logic [31:0] FONT_ROM [63] = '{
    32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88831C90,
    32'h888402F8, 32'h88882210, 32'h71CF9C10, 32'hF9CF9C70,
    32'h8228A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
    32'h8A222288, 32'h71C21C70, 32'h23C738F8, 32'h5228A480,
    32'h8A282280, 32'h8BC822F0, 32'hFA282280, 32'h8A28A480,
    32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
    32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70,
    32'h8A08A270, 32'h920DA288, 32'hA20AB288, 32'hC20AAA88,
    32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
    32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220,
    32'h82492220, 32'h81A89C20, 32'h8A28A288, 32'h8A28A288,
    32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
    32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400,
    32'h20040470, 32'h40840400, 32'h80020800, 32'hF8011000,
    32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
    32'h20821000, 32'h00022200, 32'h20800020
  };

  // Glyph index divided by five: multiply by 13/64, exact for indexes below 64.
  function automatic logic [3:0] glyph_group(input logic [GlyphW-1:0] glyph);
    logic [9:0] prod;
    prod = 10'(glyph) * 10'd13;
    return prod[9:6];
  endfunction

endpackage

@@ rtl/bitmap_text_glyph_renderer_unit.sv @@
// Bitmap text glyph renderer: draws one 6x7 glyph per printable character as seven pixel rows.
// The first row of a printable character passes from the row generator into the output
// register after its request is accepted. The row generator emits one glyph row a cycle
// while the output is not stalled; an unprintable character only advances the cursor.
// Reset: cursor and line at zero, fb_width 320, frame_base 0, no rows pending.
module bitmap_text_glyph_renderer_unit
  import btgr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CodeW-1:0]     char_code_i,
  input  logic                 string_start_i,
  input  logic [CoordW-1:0]    start_x_i,
  input  logic [CoordW-1:0]    start_y_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [AddrW-1:0]     row_address_o,
  output logic [RowW-1:0]      glyph_row_o,
  output logic [PixelW-1:0]    pixel_0_o,
  output logic [PixelW-1:0]    pixel_1_o,
  output logic [PixelW-1:0]    pixel_2_o,
  output logic [PixelW-1:0]    pixel_3_o,
  output logic [PixelW-1:0]    pixel_4_o,
  output logic [PixelW-1:0]    pixel_5_o,
  output logic                 last_row_o
);

  // Configuration registers.
  logic [StrideW-1:0]  fb_width_q;
  logic [BaseW-1:0]    frame_base_q;

  // Text cursor.
  logic [CursorW-1:0]  cursor_x_q, cursor_x_d;
  logic [CoordW-1:0]   line_y_q, line_y_d;

  // Row generator.
  logic                gen_busy_q, gen_busy_d;
  logic [RowW-1:0]     gen_row_q, gen_row_d;
  logic [WordIdxW-1:0] gen_word_q;
  logic [2:0]          gen_col_q;
  logic [CursorW-1:0]  gen_x_q;
  logic [CoordW-1:0]   gen_y_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [AddrW-1:0]    row_address_q;
  logic [RowW-1:0]     glyph_row_q;
  logic [GlyphW-1:0]   row_bits_q;

  logic                in_accept;
  logic                advance;
  logic                gen_done;
  logic [7:0]          map_entry;
  logic                printable;
  logic [GlyphW-1:0]   glyph_idx;
  logic [3:0]          group;
  logic [2:0]          col;
  logic [WordIdxW-1:0] word_base;

  logic [CursorW-1:0]  cur_x;
  logic [CoordW-1:0]   cur_y;

  logic [WordIdxW-1:0] word_idx;
  logic [31:0]         font_word;
  logic [4:0]          bit_shift;
  logic [GlyphW-1:0]   row_bits;
  logic [CoordW:0]     row_line;
  logic [20:0]         row_offset;
  logic [AddrW-1:0]    row_address;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q   <= FbWidthReset;
      frame_base_q <= FrameBaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegFbWidth:   fb_width_q   <= cfg_data_i[StrideW-1:0];
        RegFrameBase: frame_base_q <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // The generator hands its last row to the output register in the same cycle
  // that the next request is taken, so characters follow without a gap.
  assign advance    = gen_busy_q && (!out_valid_q || out_ready_i);
  assign gen_done   = advance && (gen_row_q == LastRow);
  assign in_ready_o = !gen_busy_q || gen_done;
  assign in_accept  = in_valid_i && in_ready_o;

  assign map_entry = GLYPH_MAP[char_code_i[6:0]];
  assign printable = (map_entry != NoGlyph);
  assign glyph_idx = map_entry[GlyphW-1:0];
  assign group     = glyph_group(glyph_idx);
  assign col       = 3'(glyph_idx - 6'(group) * 6'd5);
  assign word_base = 6'(group) * 6'd7;

  assign cur_x = string_start_i ? CursorW'(start_x_i) : cursor_x_q;
  assign cur_y = string_start_i ? start_y_i : line_y_q;

  always_comb begin
    cursor_x_d = cursor_x_q;
    line_y_d   = line_y_q;
    gen_busy_d = gen_busy_q;
    gen_row_d  = gen_row_q;
    if (advance) begin
      gen_row_d = gen_row_q + 3'd1;
      if (gen_done) begin
        gen_busy_d = 1'b0;
      end
    end
    if (in_accept) begin
      cursor_x_d = cur_x + GlyphAdvance;
      line_y_d   = cur_y;
      gen_busy_d = printable;
      gen_row_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      line_y_q   <= '0;
      gen_busy_q <= 1'b0;
      gen_row_q  <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      line_y_q   <= line_y_d;
      gen_busy_q <= gen_busy_d;
      gen_row_q  <= gen_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gen_word_q <= word_base;
      gen_col_q  <= col;
      gen_x_q    <= cur_x;
      gen_y_q    <= cur_y;
    end
  end

  // One glyph row: font word lookup and the row's framebuffer address.
  assign word_idx   = gen_word_q + WordIdxW'(gen_row_q);
  assign font_word  = FONT_ROM[word_idx];
  assign bit_shift  = 5'd26 - 5'(gen_col_q) * 5'd6;
  assign row_bits   = GlyphW'(font_word >> bit_shift);
  assign row_line   = (CoordW+1)'(gen_y_q) + (CoordW+1)'(gen_row_q);
  assign row_offset = 21'(fb_width_q) * 21'(row_line);
  assign row_address = AddrW'(frame_base_q) + AddrW'(row_offset) + AddrW'(gen_x_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_address_q <= row_address;
      glyph_row_q   <= gen_row_q;
      row_bits_q    <= row_bits;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = row_address_q;
  assign glyph_row_o   = glyph_row_q;
  assign pixel_0_o     = row_bits_q[5] ? PixelSet : PixelClear;
  assign pixel_1_o     = row_bits_q[4] ? PixelSet : PixelClear;
  assign pixel_2_o     = row_bits_q[3] ? PixelSet : PixelClear;
  assign pixel_3_o     = row_bits_q[2] ? PixelSet : PixelClear;
  assign pixel_4_o     = row_bits_q[1] ? PixelSet : PixelClear;
  assign pixel_5_o     = row_bits_q[0] ? PixelSet : PixelClear;
  assign last_row_o    = (glyph_row_q == LastRow);

`ifndef ASSERT_OFF
  // A printable request starts the generator at the top row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && printable |=> gen_busy_q && (gen_row_q == '0))
    else $error("generator not started at top row");

  // While a glyph is in progress, a new request is taken only as its last row leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_busy_q && in_ready_o |-> gen_done)
    else $error("request taken while glyph rows remain");

  // A row other than the last one leaving means the generator still holds the glyph.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |-> gen_busy_q)
    else $error("glyph rows lost before last row");
`endif

endmodule
